### hdl/ps2mis_pkg.sv
// ----------------------------------------------------------------------------
// ps2mis_pkg
// Types, constants, the script ROM and the time compare shared by the
// PS/2 mouse start-up script sequencer.
// ----------------------------------------------------------------------------
package ps2mis_pkg;

	localparam int SCRIPT_DEPTH = 32;
	localparam int TIME_WIDTH   = 32;
	localparam int SCRIPT_LEN   = 16;

	localparam int POS_W     = $clog2(SCRIPT_DEPTH);
	localparam int ROM_IDX_W = $clog2(SCRIPT_LEN);
	localparam int CNT_W     = 7;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;

	// register indexes of the write port
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TIMEOUT = 1'b1;

	localparam logic [CFG_W-1:0] POLL_INTERVAL_RESET = 16'd20;
	localparam logic [CFG_W-1:0] REPLY_TIMEOUT_RESET = 16'd3500;

	localparam logic [7:0] AWAIT_FLAG = 8'h80;
	localparam logic [7:0] COUNT_MASK = 8'h7f;

	localparam logic [7:0] SCRIPT_ROM [SCRIPT_LEN] = '{
		8'h01, 8'hff,
		8'h82,
		8'h08, 8'hf3, 8'd200, 8'hf3, 8'd100, 8'hf3, 8'd80, 8'hf2, 8'h01,
		8'h81,
		8'h01, 8'hf4,
		8'h00
	};

	typedef logic [TIME_WIDTH-1:0] time_t;
	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	typedef struct packed {
		logic        op;
		logic [31:0] now_ms;
		logic        rx_valid;
		logic [7:0]  rx_byte;
	} in_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_taken;
		logic       flush_rx;
		logic       done_res;
	} out_t;

	typedef struct packed {
		logic [CFG_W-1:0] poll_interval_ms;
		logic [CFG_W-1:0] reply_timeout_ms;
	} cfg_t;

	// words past the end of the script read as zero
	function automatic logic [7:0] script_word(input pos_t p);
		logic [7:0] w;
		w = 8'h00;
		if (int'(p) < SCRIPT_LEN) begin
			w = SCRIPT_ROM[ROM_IDX_W'(p)];
		end
		return w;
	endfunction

	// t has passed when now - t, read as signed, is above zero
	function automatic logic time_passed(input time_t now, input time_t t);
		time_t d;
		d = now - t;
		return (d != '0) && !d[TIME_WIDTH-1];
	endfunction

endpackage

### hdl/ps2mis_cfg.sv
// ----------------------------------------------------------------------------
// ps2mis_cfg
// Configuration registers: poll interval and reply timeout.
// ----------------------------------------------------------------------------
module ps2mis_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ps2mis_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ps2mis_pkg::CFG_W-1:0]       cfg_data,
	output ps2mis_pkg::cfg_t                   cfg
);

	ps2mis_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poll_interval_ms <= ps2mis_pkg::POLL_INTERVAL_RESET;
			cfg_q.reply_timeout_ms <= ps2mis_pkg::REPLY_TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ps2mis_pkg::CFG_POLL_INTERVAL: cfg_q.poll_interval_ms <= cfg_data;
				ps2mis_pkg::CFG_REPLY_TIMEOUT: cfg_q.reply_timeout_ms <= cfg_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/ps2mis_step.sv
// ----------------------------------------------------------------------------
// ps2mis_step
// Script state and the per-poll update: throttle, start, send, await,
// timeout. Produces one result per processed poll.
// ----------------------------------------------------------------------------
module ps2mis_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  ps2mis_pkg::in_t   item,
	input  ps2mis_pkg::cfg_t  cfg,
	output ps2mis_pkg::out_t  res
);

	ps2mis_pkg::pos_t  pos_q, pos_d, pos_e, pos_inc;
	ps2mis_pkg::cnt_t  send_q, send_d, await_q, await_d, await_dec;
	ps2mis_pkg::time_t npt_q, npt_d, dl_q, dl_d, now_t;
	logic [7:0]        word;
	logic              poll_ok;
	logic              timeout;

	always_comb begin
		now_t   = ps2mis_pkg::TIME_WIDTH'(item.now_ms);
		pos_e   = item.op ? '0 : pos_q;
		pos_inc = (pos_e == ps2mis_pkg::POS_W'(ps2mis_pkg::SCRIPT_DEPTH - 1)) ?
			'0 : pos_e + 1'b1;
		word    = ps2mis_pkg::script_word(pos_e);
		poll_ok = ps2mis_pkg::time_passed(now_t, npt_q);
		await_dec = item.rx_valid ? await_q - 1'b1 : await_q;
		timeout   = !item.rx_valid && ps2mis_pkg::time_passed(now_t, dl_q);

		pos_d   = pos_e;
		send_d  = send_q;
		await_d = await_q;
		npt_d   = npt_q;
		dl_d    = dl_q;
		res     = '0;

		if (poll_ok) begin
			npt_d = now_t + ps2mis_pkg::TIME_WIDTH'(cfg.poll_interval_ms);
			priority if (pos_e == '0) begin
				res.flush_rx = 1'b1;
				res.rx_taken = item.rx_valid;
				send_d       = ps2mis_pkg::CNT_W'(word & ps2mis_pkg::COUNT_MASK);
				await_d      = '0;
				pos_d        = pos_inc;
			end else if (await_q != '0) begin
				res.rx_taken = item.rx_valid;
				await_d      = await_dec;
				if (timeout) begin
					res.flush_rx = 1'b1;
					pos_d        = '0;
				end
				// replies complete: fetch the next script word
				if (send_q == '0 && await_dec == '0) begin
					pos_d = pos_inc;
					if ((word & ps2mis_pkg::AWAIT_FLAG) != 8'h00) begin
						await_d = ps2mis_pkg::CNT_W'(word & ps2mis_pkg::COUNT_MASK);
					end else begin
						send_d = ps2mis_pkg::CNT_W'(word & ps2mis_pkg::COUNT_MASK);
					end
				end
			end else if (send_q != '0) begin
				res.tx_valid = 1'b1;
				res.tx_byte  = word;
				pos_d        = pos_inc;
				send_d       = send_q - 1'b1;
				await_d      = ps2mis_pkg::CNT_W'(1);
				dl_d         = now_t + ps2mis_pkg::TIME_WIDTH'(cfg.reply_timeout_ms);
			end else begin
				// script ended: hold position and counts
				pos_d = pos_e;
			end
		end

		res.done_res = (pos_d != '0) && (send_d == '0) && (await_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			send_q  <= '0;
			await_q <= '0;
			npt_q   <= '0;
			dl_q    <= '0;
		end else if (fire) begin
			pos_q   <= pos_d;
			send_q  <= send_d;
			await_q <= await_d;
			npt_q   <= npt_d;
			dl_q    <= dl_d;
		end
	end

endmodule

### hdl/ps2_mouse_init_script_sequencer_unit.sv
// ----------------------------------------------------------------------------
// ps2_mouse_init_script_sequencer_unit
// PS/2 mouse start-up script sequencer: one poll in, one result out.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | beat
//  ---------+-----------+----------------------+------------------------------
//  in       | in        | in_valid / in_stall  | in_data  (op, now_ms, rx_*)
//  out      | out       | out_valid / out_stall| out_data (tx_*, rx_taken, ..)
//  cfg      | in        | cfg_we               | cfg_index, cfg_data
//
//  One beat per cycle sustained while out_stall stays low; a poll beat goes
//  to the input register, its result to the result register. The script
//  update sits between them. Reset zeroes script state, loads 20 ms / 3500 ms.
//  A stalled result holds in the result register while the next poll waits
//  in the input register; in_stall rises only when both are full.
// ----------------------------------------------------------------------------
module ps2_mouse_init_script_sequencer_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  ps2mis_pkg::in_t                  in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output ps2mis_pkg::out_t                 out_data,
	input  logic                             cfg_we,
	input  logic [ps2mis_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ps2mis_pkg::CFG_W-1:0]     cfg_data
);

	ps2mis_pkg::cfg_t cfg;
	ps2mis_pkg::in_t  item_s1;
	ps2mis_pkg::out_t res;
	ps2mis_pkg::out_t out_q;
	logic             valid_s1;
	logic             out_valid_q;
	logic             out_load;
	logic             in_take;

	assign out_load = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !out_load;
	assign in_take  = in_valid && !in_stall;

	ps2mis_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ps2mis_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (out_load),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (out_load) begin
				valid_s1 <= 1'b0;
			end
			// drop the result once taken unless a new one replaces it
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_data;
		end
		if (out_load) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### hdl/ps2mis_checker.sv
// ----------------------------------------------------------------------------
// ps2mis_checker
// Port-level checks on the result channel of the script sequencer.
// ----------------------------------------------------------------------------
module ps2mis_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             out_valid,
	input  logic             out_stall,
	input  ps2mis_pkg::out_t out_data
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

	a_tx_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.tx_valid |-> out_data.tx_byte == 8'h00)
		else $error("tx_byte set without tx_valid");

	// a send never consumes or flushes the receive path
	a_send_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tx_valid |-> !out_data.rx_taken && !out_data.flush_rx)
		else $error("send beat also touched receive path");

	// a send always leaves an acknowledge outstanding
	a_send_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tx_valid |-> !out_data.done_res)
		else $error("done reported on a send beat");

endmodule

bind ps2_mouse_init_script_sequencer_unit ps2mis_checker u_ps2mis_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

### tb/sv/ps2_mouse_init_script_sequencer_unit_test.sv
// ----------------------------------------------------------------------------
// ps2_mouse_init_script_sequencer_unit_test
// Self-checking bench for the PS/2 mouse start-up script sequencer. Polls go in
// as bursts with random gaps, results come out under a changing stall
// pattern. A local model of the script walk predicts every result beat, and
// the timing registers are rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module ps2_mouse_init_script_sequencer_unit_test;

	localparam logic OP_POLL     = 1'b0;
	localparam logic OP_RESTART  = 1'b1;
	localparam int   QUIET_LIMIT = 4000;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	ps2mis_pkg::in_t  in_data   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	ps2mis_pkg::out_t out_data;
	logic             cfg_we    = 1'b0;
	logic [ps2mis_pkg::CFG_IDX_W-1:0] cfg_index = ps2mis_pkg::CFG_POLL_INTERVAL;
	logic [ps2mis_pkg::CFG_W-1:0]     cfg_data  = '0;

	ps2_mouse_init_script_sequencer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// model state of the script walk
	logic [4:0]  seq_pos        = '0;
	logic [6:0]  bytes_to_send  = '0;
	logic [6:0]  acks_owed      = '0;
	logic [31:0] next_poll_at   = '0;
	logic [31:0] ack_deadline   = '0;
	logic [15:0] poll_gap_ms    = 16'd20;
	logic [15:0] ack_timeout_ms = 16'd3500;

	ps2mis_pkg::in_t  polls_to_send[$];
	ps2mis_pkg::out_t poll_results_due[$];

	int          failures     = 0;
	int          quiet_cycles = 0;
	int          burst_left   = 0;
	int          gap_left     = 0;
	int          stall_mode   = 0;
	int          mode_left    = 0;
	int          stall_tick   = 0;
	logic [31:0] clock_ms     = '0;
	logic [31:0] wrap_back    = '0;

	function automatic logic [7:0] script_byte(input logic [4:0] at);
		case (at)
			5'd0:    return 8'h01;
			5'd1:    return 8'hff;
			5'd2:    return 8'h82;
			5'd3:    return 8'h08;
			5'd4:    return 8'hf3;
			5'd5:    return 8'd200;
			5'd6:    return 8'hf3;
			5'd7:    return 8'd100;
			5'd8:    return 8'hf3;
			5'd9:    return 8'd80;
			5'd10:   return 8'hf2;
			5'd11:   return 8'h01;
			5'd12:   return 8'h81;
			5'd13:   return 8'h01;
			5'd14:   return 8'hf4;
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] take_word();
		logic [7:0] w;
		w = script_byte(seq_pos);
		seq_pos = seq_pos + 5'd1;
		return w;
	endfunction

	// signed-difference compare: t lies strictly in the past of now
	function automatic logic is_past(input logic [31:0] now, input logic [31:0] t);
		logic [31:0] d;
		d = now - t;
		return (d != '0) && !d[31];
	endfunction

	function automatic ps2mis_pkg::out_t poll_outcome(input ps2mis_pkg::in_t p);
		ps2mis_pkg::out_t r;
		logic [7:0]       w;
		r = '0;
		if (p.op == OP_RESTART) seq_pos = '0;
		if (is_past(p.now_ms, next_poll_at)) begin
			next_poll_at = p.now_ms + 32'(poll_gap_ms);
			if (seq_pos == '0) begin
				r.flush_rx = 1'b1;
				r.rx_taken = p.rx_valid;
				w = take_word();
				bytes_to_send = w[6:0];
				acks_owed = '0;
			end else if (acks_owed != '0) begin
				if (p.rx_valid) begin
					r.rx_taken = 1'b1;
					acks_owed = acks_owed - 7'd1;
				end else if (is_past(p.now_ms, ack_deadline)) begin
					r.flush_rx = 1'b1;
					seq_pos = '0;
				end
				if (bytes_to_send == '0 && acks_owed == '0) begin
					w = take_word();
					if (w[7]) acks_owed = w[6:0];
					else bytes_to_send = w[6:0];
				end
			end else if (bytes_to_send != '0) begin
				r.tx_valid = 1'b1;
				r.tx_byte = take_word();
				bytes_to_send = bytes_to_send - 7'd1;
				acks_owed = 7'd1;
				ack_deadline = p.now_ms + 32'(ack_timeout_ms);
			end
		end
		r.done_res = (seq_pos != '0) && (bytes_to_send == '0) && (acks_owed == '0);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			failures++;
		end
	endtask

	// driver: bursts of beats with random gaps, hold while stalled
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				poll_results_due.push_back(poll_outcome(in_data));
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0 || polls_to_send.size() == 0) begin
					in_valid <= 1'b0;
					if (gap_left != 0) gap_left <= gap_left - 1;
				end else begin
					in_valid <= 1'b1;
					in_data  <= polls_to_send.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(40, 1);
						gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	// monitor: check each result beat, then pick the next stall value
	always @(posedge clk) begin : monitor
		ps2mis_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (poll_results_due.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %0h",
					$time, out_data);
				failures++;
			end else begin
				want = poll_results_due.pop_front();
				check_field("tx_valid", 8'(want.tx_valid), 8'(out_data.tx_valid));
				check_field("tx_byte",  want.tx_byte,      out_data.tx_byte);
				check_field("rx_taken", 8'(want.rx_taken), 8'(out_data.rx_taken));
				check_field("flush_rx", 8'(want.flush_rx), 8'(out_data.flush_rx));
				check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
			end
		end
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(3, 0);
			mode_left  <= $urandom_range(100, 10);
		end else begin
			mode_left <= mode_left - 1;
		end
		stall_tick <= stall_tick + 1;
		case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= ($urandom_range(9, 0) < 3);
			2:       out_stall <= ($urandom_range(9, 0) < 7);
			default: out_stall <= (stall_tick % 3 != 0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
		$display("ps2_mouse_init_script_sequencer_unit test failed");
		$finish;
	end

	task automatic add_poll(input logic op, input logic [31:0] now, input logic rxv,
			input logic [7:0] rxb);
		ps2mis_pkg::in_t p;
		p.op       = op;
		p.now_ms   = now;
		p.rx_valid = rxv;
		p.rx_byte  = rxb;
		polls_to_send.push_back(p);
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (polls_to_send.size() != 0 || in_valid || poll_results_due.size() != 0);
	endtask

	task automatic set_timing(input logic [15:0] poll_ms, input logic [15:0] ack_ms);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= ps2mis_pkg::CFG_POLL_INTERVAL;
		cfg_data  <= poll_ms;
		@(posedge clk);
		cfg_index <= ps2mis_pkg::CFG_REPLY_TIMEOUT;
		cfg_data  <= ack_ms;
		@(posedge clk);
		cfg_we <= 1'b0;
		poll_gap_ms    = poll_ms;
		ack_timeout_ms = ack_ms;
		@(negedge clk);
	endtask

	// mostly tidy runs: restart, then polls just past the interval with acks
	// offered; the rest is noise with throttled polls, timeouts and wraps
	task automatic queue_random_polls(input int n);
		int          run_left;
		bit          tidy;
		logic        op;
		logic        rxv;
		logic [31:0] gap;
		run_left = 0;
		tidy     = 1'b1;
		for (int k = 0; k < n; k++) begin
			op = OP_POLL;
			if (run_left == 0) begin
				run_left = $urandom_range(60, 15);
				tidy     = ($urandom_range(99, 0) < 80);
				op       = OP_RESTART;
			end else if (!tidy && $urandom_range(9, 0) == 0) begin
				op = OP_RESTART;
			end
			run_left--;
			gap = 32'(poll_gap_ms) + 32'd1 + $urandom_range(4, 0);
			if (wrap_back != '0) begin
				// second half of a half-range jump: land just past the interval
				gap       = wrap_back;
				wrap_back = '0;
			end else if (!tidy) begin
				case ($urandom_range(4, 0))
					0: gap = $urandom_range(32'(poll_gap_ms), 0);
					1: gap = 32'(ack_timeout_ms) + $urandom_range(50, 1);
					2: begin
						gap       = 32'h8000_0000 + $urandom_range(255, 0);
						wrap_back = 32'h8000_0000 - (gap - 32'h8000_0000) + 32'(poll_gap_ms) + 32'd1;
					end
					3: gap = $urandom_range(32'h7fff_ffff, 1);
					default: ;
				endcase
			end else if ($urandom_range(29, 0) == 0) begin
				gap = 32'(ack_timeout_ms) + 32'(poll_gap_ms) + $urandom_range(20, 1);
			end
			clock_ms = clock_ms + gap;
			rxv = tidy ? ($urandom_range(3, 0) != 0) : 1'($urandom_range(1, 0));
			add_poll(op, clock_ms, rxv, 8'($urandom_range(255, 0)));
		end
	endtask

	task automatic run_phase(input logic [15:0] poll_ms, input logic [15:0] ack_ms, input int n);
		wait_idle();
		set_timing(poll_ms, ack_ms);
		clock_ms  = $urandom();
		wrap_back = '0;
		queue_random_polls(n);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset timing: 20 ms between polls, 3500 ms for replies
		add_poll(OP_POLL,    32'd0,    1'b0, 8'h00); // equal to next poll time: held
		add_poll(OP_POLL,    32'd1,    1'b1, 8'hff); // script start drains the byte
		add_poll(OP_POLL,    32'd5,    1'b1, 8'h00); // throttled
		add_poll(OP_POLL,    32'd30,   1'b1, 8'h00); // send, offered byte left alone
		add_poll(OP_POLL,    32'd60,   1'b0, 8'h00); // awaiting, deadline ahead
		add_poll(OP_POLL,    32'd4000, 1'b0, 8'h00); // reply timeout
		add_poll(OP_POLL,    32'd4030, 1'b0, 8'h00);
		add_poll(OP_POLL,    32'd4060, 1'b0, 8'h00);
		add_poll(OP_POLL,    32'd4090, 1'b1, 8'hfa);
		add_poll(OP_POLL,    32'd4120, 1'b1, 8'haa);
		add_poll(OP_POLL,    32'd4150, 1'b1, 8'h00);
		add_poll(OP_POLL,    32'd4180, 1'b0, 8'h00);
		add_poll(OP_RESTART, 32'hffff_fff0, 1'b1, 8'h55); // restart while time looks behind
		add_poll(OP_POLL,    32'h7fff_ffff, 1'b1, 8'h5a);
		add_poll(OP_POLL,    32'hffff_ffff, 1'b0, 8'h00); // deadline wraps past zero
		add_poll(OP_POLL,    32'h0000_0010, 1'b1, 8'h00);
		add_poll(OP_POLL,    32'h0000_0030, 1'b1, 8'h01);
		add_poll(OP_RESTART, 32'h0000_0050, 1'b0, 8'h00);

		run_phase(16'd0,     16'd0,     150);
		run_phase(16'hffff,  16'hffff,  150);
		run_phase(16'd1,     16'd40,    150);
		run_phase(16'($urandom_range(100, 0)), 16'($urandom_range(5000, 200)), 200);
		run_phase(16'd20,    16'd3500,  200);

		wait_idle();
		repeat (8) @(posedge clk);
		if (poll_results_due.size() != 0) begin
			$display("%0t: results missing, expected %0d more, actual 0", $time,
				poll_results_due.size());
			failures++;
		end
		if (failures == 0) begin
			$display("ps2_mouse_init_script_sequencer_unit test passed");
		end else begin
			$display("ps2_mouse_init_script_sequencer_unit test failed");
		end
		$finish;
	end

endmodule
